### sv/prp_pkg.sv
// shared types and constants for the paced ring producer
`timescale 1ns / 1ps

package prp_pkg;

    localparam int unsigned RING_SIZE_DEF = 32;
    localparam int unsigned CELL_WORDS    = 16;
    localparam int unsigned WORD_IDX_W    = $clog2(CELL_WORDS);
    localparam int unsigned SLOT_W        = 5;
    localparam int unsigned DATA_W        = 32;
    localparam int unsigned PACE_W        = 20;
    localparam int unsigned JOB_DEPTH     = 4;
    localparam int unsigned APB_ADDR_W    = 3;
    localparam int unsigned APB_DATA_W    = 32;

    localparam logic [PACE_W-1:0]     PACE_RESET = PACE_W'(540);
    localparam logic [WORD_IDX_W-1:0] TS_WORD    = WORD_IDX_W'(1);
    localparam logic [WORD_IDX_W-1:0] LAST_WORD  = WORD_IDX_W'(CELL_WORDS - 1);

    // register index, taken from paddr[2]
    localparam logic REG_PACE_INTERVAL = 1'b0;

    typedef enum logic {
        KIND_WORD   = 1'b0,
        KIND_NOTICE = 1'b1
    } t_kind;

    // one unit of work handed from the front to the back
    typedef struct packed {
        t_kind             kind;
        logic [SLOT_W-1:0] slot;
        logic [DATA_W-1:0] wi;
        logic [DATA_W-1:0] ts;
        logic [DATA_W-1:0] blk;
    } t_job;

endpackage

### sv/prp_front.sv
// tick classification: pacing, ring-full check and producer state
`timescale 1ns / 1ps

module prp_front import prp_pkg::*; #(
    parameter int unsigned RING_SIZE = RING_SIZE_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_tick,
    input  logic [DATA_W-1:0] i_wall_time,
    input  logic [DATA_W-1:0] i_consumer_index,
    input  logic [PACE_W-1:0] i_pace_interval,
    output logic              o_push,
    output t_job              o_job
);

    localparam int unsigned SLOT_CNT_W = (RING_SIZE > 1) ? $clog2(RING_SIZE) : 1;
    localparam logic [SLOT_CNT_W-1:0] SLOT_MAX = SLOT_CNT_W'(RING_SIZE - 1);

    logic [DATA_W-1:0]     r_wi, n_wi;
    logic [DATA_W-1:0]     r_deadline, n_deadline;
    logic [DATA_W-1:0]     r_blk, n_blk;
    logic                  r_wait, n_wait;
    logic                  r_armed, n_armed;
    logic [SLOT_CNT_W-1:0] r_slot, n_slot;

    logic              w_full;
    logic              w_pace_nz;
    logic [DATA_W-1:0] w_pace_ext;
    logic [DATA_W-1:0] w_lag;
    logic [DATA_W-1:0] w_slot_ext;
    logic              w_go;
    logic              w_publish;
    logic              w_notice;

    assign w_full     = (r_wi - i_consumer_index) >= DATA_W'(RING_SIZE);
    assign w_pace_nz  = |i_pace_interval;
    assign w_pace_ext = DATA_W'(i_pace_interval);
    assign w_lag      = i_wall_time - r_deadline;
    assign w_slot_ext = DATA_W'(r_slot);

    always_comb begin
        n_wi       = r_wi;
        n_deadline = r_deadline;
        n_blk      = r_blk;
        n_wait     = r_wait;
        n_armed    = r_armed;
        n_slot     = r_slot;
        w_go       = 1'b0;
        w_publish  = 1'b0;
        w_notice   = 1'b0;
        if (i_tick) begin
            if (r_wait) begin
                if (!w_full) begin
                    w_publish = 1'b1;
                    n_wait    = 1'b0;
                end
            end else begin
                // pacing gate; a fresh deadline with a nonzero interval is never already due
                if (!r_armed) begin
                    n_armed = 1'b1;
                    if (w_pace_nz) begin
                        n_deadline = i_wall_time + w_pace_ext;
                    end else begin
                        n_deadline = i_wall_time;
                        w_go       = 1'b1;
                    end
                end else if (w_pace_nz) begin
                    if (!w_lag[DATA_W-1]) begin
                        n_deadline = r_deadline + w_pace_ext;
                        w_go       = 1'b1;
                    end
                end else begin
                    n_deadline = i_wall_time;
                    w_go       = 1'b1;
                end
                if (w_go) begin
                    if (w_full) begin
                        w_notice = 1'b1;
                        n_blk    = r_blk + DATA_W'(1);
                        n_wait   = 1'b1;
                    end else begin
                        w_publish = 1'b1;
                    end
                end
            end
            if (w_publish) begin
                n_wi = r_wi + DATA_W'(1);
                // slot restarts on 32-bit wrap too, so it stays wi mod size
                if (r_wi == '1 || r_slot == SLOT_MAX) begin
                    n_slot = '0;
                end else begin
                    n_slot = r_slot + SLOT_CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wi       <= '0;
            r_deadline <= '0;
            r_blk      <= '0;
            r_wait     <= 1'b0;
            r_armed    <= 1'b0;
            r_slot     <= '0;
        end else begin
            r_wi       <= n_wi;
            r_deadline <= n_deadline;
            r_blk      <= n_blk;
            r_wait     <= n_wait;
            r_armed    <= n_armed;
            r_slot     <= n_slot;
        end
    end

    assign o_push     = w_publish | w_notice;
    assign o_job.kind = w_notice ? KIND_NOTICE : KIND_WORD;
    assign o_job.slot = w_slot_ext[SLOT_W-1:0];
    assign o_job.wi   = r_wi;
    assign o_job.ts   = i_wall_time;
    assign o_job.blk  = n_blk;

endmodule

### sv/prp_queue.sv
// short job queue between front and back
`timescale 1ns / 1ps

module prp_queue import prp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output t_job o_job,
    output logic o_empty,
    output logic o_full
);

    localparam int unsigned PTR_W = $clog2(JOB_DEPTH);

    t_job             r_mem [JOB_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W:0]   r_count;

    logic w_do_push;
    logic w_do_pop;

    assign o_empty   = (r_count == '0);
    assign o_full    = (r_count == (PTR_W+1)'(JOB_DEPTH));
    assign w_do_push = i_push & ~o_full;
    assign w_do_pop  = i_pop & ~o_empty;
    assign o_job     = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (w_do_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + (PTR_W+1)'(1);
            end else if (!w_do_push && w_do_pop) begin
                r_count <= r_count - (PTR_W+1)'(1);
            end
        end
    end

endmodule

### sv/prp_back.sv
// cell word sequencer with registered output beat
`timescale 1ns / 1ps

module prp_back import prp_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_job                  i_job,
    input  logic                  i_job_avail,
    output logic                  o_pop,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic                  o_kind,
    output logic [SLOT_W-1:0]     o_slot,
    output logic [WORD_IDX_W-1:0] o_word_index,
    output logic [DATA_W-1:0]     o_word_data,
    output logic [DATA_W-1:0]     o_new_write_index,
    output logic [DATA_W-1:0]     o_blocked_total,
    output logic                  o_last
);

    t_job                  r_job;
    logic                  r_act;
    logic [WORD_IDX_W-1:0] r_word;
    logic                  r_ov;

    t_kind                 r_kind;
    logic [SLOT_W-1:0]     r_slot;
    logic [WORD_IDX_W-1:0] r_widx;
    logic [DATA_W-1:0]     r_data;
    logic [DATA_W-1:0]     r_nwi;
    logic [DATA_W-1:0]     r_blk;
    logic                  r_last;

    logic              w_notice;
    logic              w_last_word;
    logic              w_load;
    logic [DATA_W-1:0] w_wi_inc;

    assign w_notice    = (r_job.kind == KIND_NOTICE);
    assign w_last_word = w_notice || (r_word == LAST_WORD);
    assign w_load      = r_act && (!r_ov || i_ready);
    assign o_pop       = i_job_avail && (!r_act || (w_load && w_last_word));
    assign w_wi_inc    = r_job.wi + DATA_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act  <= 1'b0;
            r_word <= '0;
            r_ov   <= 1'b0;
        end else begin
            if (o_pop) begin
                r_act  <= 1'b1;
                r_word <= '0;
            end else if (w_load && w_last_word) begin
                r_act <= 1'b0;
            end else if (w_load) begin
                r_word <= r_word + WORD_IDX_W'(1);
            end
            if (w_load) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
        if (w_load) begin
            r_kind <= r_job.kind;
            r_slot <= r_job.slot;
            r_blk  <= r_job.blk;
            r_last <= w_last_word;
            if (w_notice) begin
                r_widx <= '0;
                r_data <= '0;
                r_nwi  <= r_job.wi;
            end else begin
                r_widx <= r_word;
                r_data <= (r_word == TS_WORD) ? r_job.ts : r_job.wi;
                r_nwi  <= (r_word == LAST_WORD) ? w_wi_inc : '0;
            end
        end
    end

    assign o_valid           = r_ov;
    assign o_kind            = r_kind;
    assign o_slot            = r_slot;
    assign o_word_index      = r_widx;
    assign o_word_data       = r_data;
    assign o_new_write_index = r_nwi;
    assign o_blocked_total   = r_blk;
    assign o_last            = r_last;

endmodule

### sv/paced_ring_producer_unit.sv
// top level of the paced ring producer: config register, front, queue, back
`timescale 1ns / 1ps

// channel   | direction | handshake             | payload
// tick in   | in        | i_valid / o_ready     | i_wall_time, i_consumer_index
// cell out  | out       | o_valid / i_ready     | kind, slot, word index/data, indexes, last
// config    | in        | psel/penable/pready   | paddr, pwdata, prdata (pace interval)
//
// a tick is taken every cycle while the job queue has room; its decision is made
// in the cycle it is taken, by one 32-bit subtract/compare for the ring and one for pacing
// a publish is 16 beats from the back sequencer, one per ready cycle; a notice is one beat
// output stalls only hold the back; the front keeps taking ticks until the queue fills
// synchronous active-low reset clears all producer state; no memory clearing pass
// first beat of a job passes from its tick through the queue, the back's job register, then the output register

module paced_ring_producer_unit import prp_pkg::*; #(
    parameter int unsigned RING_SIZE = RING_SIZE_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // tick channel
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [DATA_W-1:0]     i_wall_time,
    input  logic [DATA_W-1:0]     i_consumer_index,
    // result channel
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic                  o_kind,
    output logic [SLOT_W-1:0]     o_slot,
    output logic [WORD_IDX_W-1:0] o_word_index,
    output logic [DATA_W-1:0]     o_word_data,
    output logic [DATA_W-1:0]     o_new_write_index,
    output logic [DATA_W-1:0]     o_blocked_total,
    output logic                  o_last,
    // configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [PACE_W-1:0] r_pace_interval;

    logic w_cfg_wr;
    logic w_tick;
    logic w_push;
    t_job w_push_job;
    t_job w_head_job;
    logic w_q_empty;
    logic w_q_full;
    logic w_pop;

    // register file: a single pace interval register at byte address 0
    assign pready   = 1'b1;
    assign w_cfg_wr = psel & penable & pwrite & pready & (paddr[2] == REG_PACE_INTERVAL);
    assign prdata   = (paddr[2] == REG_PACE_INTERVAL) ? APB_DATA_W'(r_pace_interval) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pace_interval <= PACE_RESET;
        end else if (w_cfg_wr) begin
            r_pace_interval <= pwdata[PACE_W-1:0];
        end
    end

    // ticks are taken whenever the queue can hold whatever they may cause
    assign o_ready = ~w_q_full;
    assign w_tick  = i_valid & o_ready;

    prp_front #(
        .RING_SIZE (RING_SIZE)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_tick           (w_tick),
        .i_wall_time      (i_wall_time),
        .i_consumer_index (i_consumer_index),
        .i_pace_interval  (r_pace_interval),
        .o_push           (w_push),
        .o_job            (w_push_job)
    );

    prp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .i_pop   (w_pop),
        .o_job   (w_head_job),
        .o_empty (w_q_empty),
        .o_full  (w_q_full)
    );

    prp_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_job             (w_head_job),
        .i_job_avail       (~w_q_empty),
        .o_pop             (w_pop),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_kind            (o_kind),
        .o_slot            (o_slot),
        .o_word_index      (o_word_index),
        .o_word_data       (o_word_data),
        .o_new_write_index (o_new_write_index),
        .o_blocked_total   (o_blocked_total),
        .o_last            (o_last)
    );

`ifndef SYNTH
    // last word of a cell publishes the index right after the one it carries
    a_last_word_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last && o_kind == KIND_WORD) |->
            (o_new_write_index == o_word_data + DATA_W'(1)))
        else $error("published index does not follow cell sequence number");

    // a notice is always a single closing beat at word zero
    a_notice_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind == KIND_NOTICE) |-> (o_last && o_word_index == '0))
        else $error("blocked notice malformed");

    // words of a cell follow each other without a gap
    a_word_sequence: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && !o_last) |=>
            (o_valid && o_word_index == $past(o_word_index) + WORD_IDX_W'(1)))
        else $error("cell words out of sequence");

    // queue never pushed while full
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_q_full)
        else $error("job queue overflow");
`endif

endmodule
